[rtl/core/ipcls_pkg.sv]
// Shared beat types and grammar constants for the IP address line classifier.
package ipcls_pkg;

    localparam int unsigned TOTAL_W = 32;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TOTAL_W-1:0] ipv4_total;
        logic [TOTAL_W-1:0] ipv6_total;
        logic [TOTAL_W-1:0] invalid_total;
    } t_out_beat;

    localparam logic [1:0] KIND_IPV4    = 2'd0;
    localparam logic [1:0] KIND_IPV6    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    localparam logic [1:0] V4_DOTS      = 2'd3;
    localparam logic [1:0] DIGIT_SAT    = 2'd3;
    localparam logic [8:0] GROUP_MAX    = 9'd255;
    localparam logic [8:0] GROUP_SAT    = 9'd256;
    localparam logic [2:0] V6_COLONS    = 3'd7;
    localparam logic [2:0] HEX_GROUP_MAX = 3'd4;

endpackage

[rtl/core/ip_address_line_classifier.sv]
// Top level of the IP address line classifier: grammar checks, totals and beat registers.
//
// Usage: the input channel carries one character of a text line per beat,
// with line_end set on the last character (the newline itself is not sent).
// Every character advances an IPv4 and an IPv6 grammar check in parallel.
// The beat carrying line_end produces exactly one output beat with the
// line's class (IPv4, IPv6 or invalid) and the saturating running totals of
// each class, including this line. Other beats produce no output.
// A beat is captured in the input register, is classified by combinational
// logic and lands in the output register, where o_valid rises. Throughput is
// one character per cycle while the output is not stalled; the single-pass
// update of the per-line state between the two registers sets that figure.
// When the receiver asserts i_stall while a result is pending, the output
// beat holds; the input register still drains into the pipeline as long as
// the output register is free, and o_stall rises only when both the output
// register and the input register are full and the output is stalled.
// Reset (i_rst_n low, synchronous) empties both registers, clears the
// per-line grammar state and zeroes the three totals.
module ip_address_line_classifier
    import ipcls_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_beat
);

    // Input register.
    logic     r_in_valid;
    t_in_beat r_in_beat;

    // Output register.
    logic      r_out_valid;
    t_out_beat r_out_beat;

    // Per-line grammar state.
    logic       r_v4_ok;
    logic [1:0] r_dot_seen;
    logic [8:0] r_group_value;
    logic [1:0] r_digit_count;
    logic       r_lead_zero;
    logic       r_v6_ok;
    logic [2:0] r_colon_seen;
    logic [2:0] r_hex_len;

    // Running totals.
    logic [COUNT_WIDTH-1:0] r_v4_cnt;
    logic [COUNT_WIDTH-1:0] r_v6_cnt;
    logic [COUNT_WIDTH-1:0] r_bad_cnt;

    logic       n_v4_ok;
    logic [1:0] n_dot_seen;
    logic [8:0] n_group_value;
    logic [1:0] n_digit_count;
    logic       n_lead_zero;
    logic       n_v6_ok;
    logic [2:0] n_colon_seen;
    logic [2:0] n_hex_len;
    logic [COUNT_WIDTH-1:0] n_v4_cnt;
    logic [COUNT_WIDTH-1:0] n_v6_cnt;
    logic [COUNT_WIDTH-1:0] n_bad_cnt;
    logic [1:0] n_kind;

    logic        out_free;
    logic        s1_go;
    logic [7:0]  ch;
    logic        is_digit;
    logic        is_hex;
    logic [3:0]  digit;
    logic [11:0] group_wide;
    logic        v4_line;
    logic        v6_line;

    // The output register can take a new beat when it is empty or being read.
    assign out_free = !r_out_valid || !i_stall;
    // Every beat in the input register moves on together with the pipeline.
    assign s1_go    = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_beat   = r_out_beat;

    assign ch       = r_in_beat.ch;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_hex   = is_digit || ((ch >= CH_UC_A) && (ch <= CH_UC_F))
                      || ((ch >= CH_LC_A) && (ch <= CH_LC_F));
    assign digit    = 4'(ch - CH_ZERO);
    // At most 256 * 10 + 9, which fits twelve bits.
    assign group_wide = 12'(r_group_value) * 12'd10 + 12'(digit);

    always_comb begin
        n_v4_ok       = r_v4_ok;
        n_dot_seen    = r_dot_seen;
        n_group_value = r_group_value;
        n_digit_count = r_digit_count;
        n_lead_zero   = r_lead_zero;

        if (is_digit) begin
            if (r_digit_count == 2'd0) begin
                n_lead_zero = (ch == CH_ZERO);
            end else if (r_lead_zero) begin
                n_v4_ok = 1'b0;
            end
            n_group_value = (group_wide > 12'(GROUP_SAT)) ? GROUP_SAT : group_wide[8:0];
            if (r_digit_count < DIGIT_SAT) begin
                n_digit_count = r_digit_count + 2'd1;
            end
        end else if (ch == CH_DOT) begin
            if (r_digit_count == 2'd0 || r_group_value > GROUP_MAX
                || r_dot_seen >= V4_DOTS) begin
                n_v4_ok = 1'b0;
            end else begin
                n_dot_seen = r_dot_seen + 2'd1;
            end
            n_group_value = '0;
            n_digit_count = '0;
            n_lead_zero   = 1'b0;
        end else begin
            n_v4_ok = 1'b0;
        end
    end

    always_comb begin
        n_v6_ok      = r_v6_ok;
        n_colon_seen = r_colon_seen;
        n_hex_len    = r_hex_len;

        if (is_hex) begin
            if (r_hex_len >= HEX_GROUP_MAX) begin
                n_v6_ok = 1'b0;
            end else begin
                n_hex_len = r_hex_len + 3'd1;
            end
        end else if (ch == CH_COLON) begin
            if (r_hex_len == 3'd0 || r_colon_seen >= V6_COLONS) begin
                n_v6_ok = 1'b0;
            end else begin
                n_colon_seen = r_colon_seen + 3'd1;
            end
            n_hex_len = '0;
        end else begin
            n_v6_ok = 1'b0;
        end
    end

    // Line verdict from the state after this character; IPv4 wins a tie.
    assign v4_line = n_v4_ok && (n_dot_seen == V4_DOTS) && (n_digit_count != 2'd0)
                     && (n_group_value <= GROUP_MAX);
    assign v6_line = n_v6_ok && (n_colon_seen == V6_COLONS) && (n_hex_len != 3'd0);

    always_comb begin
        n_v4_cnt  = r_v4_cnt;
        n_v6_cnt  = r_v6_cnt;
        n_bad_cnt = r_bad_cnt;
        priority if (v4_line) begin
            n_kind = KIND_IPV4;
            if (r_v4_cnt != '1) begin
                n_v4_cnt = r_v4_cnt + COUNT_WIDTH'(1);
            end
        end else if (v6_line) begin
            n_kind = KIND_IPV6;
            if (r_v6_cnt != '1) begin
                n_v6_cnt = r_v6_cnt + COUNT_WIDTH'(1);
            end
        end else begin
            n_kind = KIND_INVALID;
            if (r_bad_cnt != '1) begin
                n_bad_cnt = r_bad_cnt + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_v4_ok       <= 1'b1;
            r_dot_seen    <= '0;
            r_group_value <= '0;
            r_digit_count <= '0;
            r_lead_zero   <= 1'b0;
            r_v6_ok       <= 1'b1;
            r_colon_seen  <= '0;
            r_hex_len     <= '0;
            r_v4_cnt      <= '0;
            r_v6_cnt      <= '0;
            r_bad_cnt     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end

            if (s1_go && r_in_beat.line_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s1_go) begin
                if (r_in_beat.line_end) begin
                    // The line is finished: grammar state starts over.
                    r_v4_ok       <= 1'b1;
                    r_dot_seen    <= '0;
                    r_group_value <= '0;
                    r_digit_count <= '0;
                    r_lead_zero   <= 1'b0;
                    r_v6_ok       <= 1'b1;
                    r_colon_seen  <= '0;
                    r_hex_len     <= '0;
                    r_v4_cnt      <= n_v4_cnt;
                    r_v6_cnt      <= n_v6_cnt;
                    r_bad_cnt     <= n_bad_cnt;
                end else begin
                    r_v4_ok       <= n_v4_ok;
                    r_dot_seen    <= n_dot_seen;
                    r_group_value <= n_group_value;
                    r_digit_count <= n_digit_count;
                    r_lead_zero   <= n_lead_zero;
                    r_v6_ok       <= n_v6_ok;
                    r_colon_seen  <= n_colon_seen;
                    r_hex_len     <= n_hex_len;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_beat <= i_beat;
        end
        if (s1_go && r_in_beat.line_end) begin
            r_out_beat.kind          <= n_kind;
            r_out_beat.ipv4_total    <= TOTAL_W'(n_v4_cnt);
            r_out_beat.ipv6_total    <= TOTAL_W'(n_v6_cnt);
            r_out_beat.invalid_total <= TOTAL_W'(n_bad_cnt);
        end
    end

`ifndef ASSERT_OFF
    // A character that does not end a line never creates an output beat.
    a_no_result_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !r_in_beat.line_end) |=> !$rose(o_valid))
        else $error("output beat created by a mid-line character");

    // After the last character of a line the grammar state is back at its start.
    a_line_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_in_beat.line_end) |=> (r_v4_ok && r_v6_ok && r_dot_seen == 2'd0
            && r_colon_seen == 3'd0 && r_hex_len == 3'd0 && r_digit_count == 2'd0))
        else $error("per-line state not cleared at end of line");

    // A reported class always has a nonzero total for that class.
    a_total_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_beat.kind == KIND_IPV4 && o_beat.ipv4_total != '0)
            || (o_beat.kind == KIND_IPV6 && o_beat.ipv6_total != '0)
            || (o_beat.kind == KIND_INVALID && o_beat.invalid_total != '0)))
        else $error("reported class has a zero total");

    // Back-pressure reaches the input only when both registers are full.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");
`endif

endmodule

[dv/tb_ip_address_line_classifier.sv]
// Self-checking testbench for the IP address line classifier: directed lines, then random lines.
module tb_ip_address_line_classifier;
    import ipcls_pkg::*;

    // Counter width of the instance; the totals on the output carry its low bits.
    localparam int unsigned COUNT_W       = 32;
    // About this many characters go out in the random part.
    localparam int unsigned RANDOM_CHARS  = 1560;
    // A few spare cycles after the last result catch stray beats.
    localparam int unsigned DRAIN_CYCLES  = 8;
    // The slowest correct run is near 1900 characters, each behind the longest gap,
    // plus the longest stall on every result. The limit leaves ample margin over that.
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef logic [7:0] t_char_q[$];

    // One row of the directed table. Where the class is plain at a glance it is
    // typed in; the totals always come from the line predictor.
    typedef struct {
        string      text;
        bit         kind_known;
        logic [1:0] kind;
        bit         has_tail;
        logic [7:0] tail;
    } t_line_case;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_beat;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_beat;

    ip_address_line_classifier #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_beat  (i_beat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (o_beat)
    );

    always #10 i_clk = ~i_clk;

    // Predicted per-line grammar state, kept apart from the block.
    logic             v4_alive;
    logic [2:0]       dots_taken;
    logic [8:0]       dec_value;
    logic [1:0]       dec_digits;
    logic             dec_lead_zero;
    logic             v6_alive;
    logic [3:0]       colons_taken;
    logic [2:0]       hex_len;
    logic [COUNT_W-1:0] v4_lines;
    logic [COUNT_W-1:0] v6_lines;
    logic [COUNT_W-1:0] bad_lines;

    t_out_beat  pending_verdicts[$];
    t_line_case line_cases[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    // When set, neither side inserts gaps, so some lines run back to back.
    bit          no_idle = 1'b0;

    function automatic void clear_line_state();
        v4_alive      = 1'b1;
        dots_taken    = '0;
        dec_value     = '0;
        dec_digits    = '0;
        dec_lead_zero = 1'b0;
        v6_alive      = 1'b1;
        colons_taken  = '0;
        hex_len       = '0;
    endfunction

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] n);
        return (n == '1) ? n : n + 1'b1;
    endfunction

    // Advances both grammars by one character. On the last character of a line it
    // returns the class and the totals that the block should report, then starts
    // a fresh line.
    task automatic classify_char(input logic [7:0] c, input logic last,
                                 output bit produced, output t_out_beat verdict);
        int unsigned grown;
        logic is_digit;
        logic is_hex;
        logic v4_match;
        logic v6_match;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_hex   = is_digit || ((c >= CH_UC_A) && (c <= CH_UC_F)) ||
                   ((c >= CH_LC_A) && (c <= CH_LC_F));
        produced = 1'b0;
        verdict  = '0;

        // Dotted decimal: the group value clamps at 256 so long digit runs stay bounded.
        if (is_digit) begin
            if (dec_digits == 0) begin
                dec_lead_zero = (c == CH_ZERO);
            end else if (dec_lead_zero) begin
                v4_alive = 1'b0;
            end
            grown = dec_value * 10 + (c - CH_ZERO);
            dec_value = (grown > GROUP_SAT) ? GROUP_SAT : grown[8:0];
            if (dec_digits < DIGIT_SAT) dec_digits++;
        end else if (c == CH_DOT) begin
            if (dec_digits == 0 || dec_value > GROUP_MAX || dots_taken >= V4_DOTS) begin
                v4_alive = 1'b0;
            end else begin
                dots_taken++;
            end
            dec_value     = '0;
            dec_digits    = '0;
            dec_lead_zero = 1'b0;
        end else begin
            v4_alive = 1'b0;
        end

        // Colon hex: groups of one to four hex digits in either case.
        if (is_hex) begin
            if (hex_len >= HEX_GROUP_MAX) v6_alive = 1'b0;
            else hex_len++;
        end else if (c == CH_COLON) begin
            if (hex_len == 0 || colons_taken >= V6_COLONS) v6_alive = 1'b0;
            else colons_taken++;
            hex_len = '0;
        end else begin
            v6_alive = 1'b0;
        end

        if (last) begin
            v4_match = v4_alive && dots_taken == V4_DOTS && dec_digits != 0 &&
                       dec_value <= GROUP_MAX;
            v6_match = v6_alive && colons_taken == V6_COLONS && hex_len != 0;
            // Dotted decimal is tried first, as in the block.
            if (v4_match) begin
                verdict.kind = KIND_IPV4;
                v4_lines = bump(v4_lines);
            end else if (v6_match) begin
                verdict.kind = KIND_IPV6;
                v6_lines = bump(v6_lines);
            end else begin
                verdict.kind = KIND_INVALID;
                bad_lines = bump(bad_lines);
            end
            verdict.ipv4_total    = v4_lines[TOTAL_W-1:0];
            verdict.ipv6_total    = v6_lines[TOTAL_W-1:0];
            verdict.invalid_total = bad_lines[TOTAL_W-1:0];
            produced = 1'b1;
            clear_line_state();
        end
    endtask

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_case(input string text, input bit known,
                                     input logic [1:0] kind, input bit has_tail = 1'b0,
                                     input logic [7:0] tail = 8'h00);
        t_line_case row;
        row.text       = text;
        row.kind_known = known;
        row.kind       = kind;
        row.has_tail   = has_tail;
        row.tail       = tail;
        line_cases.insert(line_cases.size(), row);
    endfunction

    // Drives one character beat, holding it until the block takes it, and then
    // records what that character should produce.
    task automatic send_char(input logic [7:0] c, input logic last,
                             input bit hint_valid, input logic [1:0] hint);
        int gap;
        bit produced;
        t_out_beat verdict;
        gap = no_idle ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= '{ch: c, line_end: last};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        classify_char(c, last, produced, verdict);
        if (produced) begin
            if (hint_valid) verdict.kind = hint;
            pending_verdicts.insert(pending_verdicts.size(), verdict);
        end
    endtask

    task automatic send_line(input t_char_q line, input bit hint_valid,
                             input logic [1:0] hint);
        no_idle = ($urandom_range(0, 5) == 0);
        foreach (line[i]) begin
            send_char(line[i], i == line.size() - 1, hint_valid, hint);
        end
    endtask

    // Dotted decimal line; most groups are in range, some overflow, some carry a
    // leading zero and some sit on the 255 boundary.
    function automatic t_char_q make_v4_line();
        t_char_q q;
        string s;
        int unsigned r;
        for (int g = 0; g < 4; g++) begin
            if (g > 0) q.insert(q.size(), CH_DOT);
            r = $urandom_range(0, 9);
            if (r < 5) s = $sformatf("%0d", $urandom_range(0, 255));
            else if (r < 6) s = $sformatf("%0d", $urandom_range(0, 9));
            else if (r < 7) s = $sformatf("%0d", $urandom_range(250, 259));
            else if (r < 8) s = $sformatf("%0d", $urandom_range(256, 999));
            else if (r < 9) s = $sformatf("0%0d", $urandom_range(0, 99));
            else s = $sformatf("%0d", $urandom_range(1000, 99999));
            for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
        end
        return q;
    endfunction

    // Colon hex line of eight groups; now and then a group is empty or too long.
    function automatic t_char_q make_v6_line();
        t_char_q q;
        int len;
        int unsigned d;
        for (int g = 0; g < 8; g++) begin
            if (g > 0) q.insert(q.size(), CH_COLON);
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                d = $urandom_range(0, 21);
                if (d < 10) q.insert(q.size(), 8'(CH_ZERO + d));
                else if (d < 16) q.insert(q.size(), 8'(CH_LC_A + (d - 10)));
                else q.insert(q.size(), 8'(CH_UC_A + (d - 16)));
            end
        end
        if (q.size() == 0) q.insert(q.size(), CH_COLON);
        return q;
    endfunction

    // Breaks a well-formed line in one spot: a character replaced, dropped or
    // inserted, or the tail cut off.
    function automatic t_char_q mutate(input t_char_q q);
        int pos;
        logic [7:0] c;
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 3))
            0: c = CH_DOT;
            1: c = CH_COLON;
            2: c = CH_ZERO;
            default: c = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
            0: q[pos] = c;
            1: if (q.size() > 1) q.delete(pos);
            2: q.insert(pos, c);
            default: if (pos > 0) q = q[0:pos-1];
        endcase
        return q;
    endfunction

    function automatic t_char_q make_noise_line();
        t_char_q q;
        string alphabet;
        int len;
        alphabet = "0123456789.:abcdefABCDEFgx ";
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 0) q.insert(q.size(), 8'($urandom_range(0, 255)));
            else q.insert(q.size(), alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
        return q;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: every beat the block hands over is matched against the
    // oldest pending line verdict.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual kind %0d",
                         $time, o_beat.kind);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_beat.kind));
                compare_field("ipv4_total", want.ipv4_total, o_beat.ipv4_total);
                compare_field("ipv6_total", want.ipv6_total, o_beat.ipv6_total);
                compare_field("invalid_total", want.invalid_total, o_beat.invalid_total);
            end
        end
    end

    // Receiver back-pressure: stall bursts of random length with free cycles between.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            n = no_idle ? 0 : idle_len();
            if (n > 0 && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_char_q line;
        int unsigned chars_sent;
        int unsigned r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_beat  = '0;
        clear_line_state();
        v4_lines  = '0;
        v6_lines  = '0;
        bad_lines = '0;

        // Directed lines: the limits of both grammars and each way a line can fail.
        add_case("0.0.0.0", 1, KIND_IPV4);
        add_case("255.255.255.255", 1, KIND_IPV4);
        add_case("256.1.1.1", 1, KIND_INVALID);
        add_case("99999.1.1.1", 1, KIND_INVALID);
        add_case("01.2.3.4", 1, KIND_INVALID);
        add_case("1.2.3", 1, KIND_INVALID);
        add_case("1.2.3.4.5", 1, KIND_INVALID);
        add_case(".1.2.3", 1, KIND_INVALID);
        add_case("1..2.3", 1, KIND_INVALID);
        add_case("1.2.3.", 1, KIND_INVALID);
        add_case("1.2.3.4", 1, KIND_INVALID, 1, 8'h00);
        add_case("1.2.3.4", 1, KIND_INVALID, 1, 8'h0D);
        add_case("0:0:0:0:0:0:0:0", 1, KIND_IPV6);
        add_case("ffff:FFFF:abcd:ABCD:0123:4567:89ab:cdef", 1, KIND_IPV6);
        add_case("1:2:3:4:5:6:7", 1, KIND_INVALID);
        add_case("1:2:3:4:5:6:7:8:9", 1, KIND_INVALID);
        add_case("12345:1:1:1:1:1:1:1", 1, KIND_INVALID);
        add_case(":1:2:3:4:5:6:7", 1, KIND_INVALID);
        add_case("1::2:3:4:5:6:7", 1, KIND_INVALID);
        add_case("1:2:3:4:5:6:7:", 1, KIND_INVALID);
        add_case("g:1:2:3:4:5:6:7", 1, KIND_INVALID);
        add_case("7", 1, KIND_INVALID, 1, 8'hFF);
        add_case("10.20.30.40:1", 0, KIND_INVALID);
        add_case("192.168.1.254", 0, KIND_INVALID);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_cases[k]) begin
            line.delete();
            for (int i = 0; i < line_cases[k].text.len(); i++) begin
                line.insert(line.size(), line_cases[k].text[i]);
            end
            if (line_cases[k].has_tail) line.insert(line.size(), line_cases[k].tail);
            send_line(line, line_cases[k].kind_known, line_cases[k].kind);
        end

        // Random lines: mostly well formed with random content, some broken, some noise.
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            r = $urandom_range(0, 99);
            if (r < 45) line = make_v4_line();
            else if (r < 85) line = make_v6_line();
            else line = make_noise_line();
            if (r < 85 && $urandom_range(0, 3) == 0) line = mutate(line);
            send_line(line, 1'b0, KIND_INVALID);
            chars_sent += line.size();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_verdicts.size() != 0) begin
            $display("%0t: line results missing, expected %0d more, actual 0", $time,
                     pending_verdicts.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
